/* design/fcrs_pkg.sv */
// shared types, constants and functions of the flash config record scanner
`default_nettype none
package fcrs_pkg;

	localparam int FCRS_MAX_SLOTS = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_LEN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_NRM = 3'd4;

	localparam logic [31:0] MAGIC_RESET   = 32'h4343_4647;
	localparam logic [15:0] VERSION_RESET = 16'd1;
	localparam logic [9:0]  CUR_LEN_RESET = 10'd256;
	localparam logic [7:0]  NORMAL_RESET  = 8'd1;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [7:0]  BLANK_BYTE = 8'hFF;

	localparam logic [15:0] LEN_V8 = 16'd253;
	localparam logic [15:0] LEN_V7 = 16'd249;
	localparam logic [15:0] LEN_V6 = 16'd243;
	localparam logic [15:0] LEN_V5 = 16'd239;

	// byte position saturates well above the longest header plus payload
	localparam int POS_W = 11;
	localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] HDR_BYTES = 11'd12;
	localparam logic [POS_W-1:0] MODE_POS  = 11'd255;

	typedef enum logic [2:0] {
		CLS_NONE = 3'd0,
		CLS_CUR  = 3'd1,
		CLS_V8   = 3'd2,
		CLS_V7   = 3'd3,
		CLS_V6   = 3'd4,
		CLS_V5   = 3'd5
	} rec_class_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] version;
		logic [9:0]  cur_len;
		logic [7:0]  normal_code;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       blank;
		rec_class_t cls;
		logic       normal;
	} slot_res_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// current length is checked before the legacy ones
	function automatic rec_class_t length_class(input logic [15:0] len, input logic [9:0] cur);
		rec_class_t c;
		if (len == {6'd0, cur}) c = CLS_CUR;
		else if (len == LEN_V8) c = CLS_V8;
		else if (len == LEN_V7) c = CLS_V7;
		else if (len == LEN_V6) c = CLS_V6;
		else if (len == LEN_V5) c = CLS_V5;
		else c = CLS_NONE;
		return c;
	endfunction

endpackage
`default_nettype wire

/* design/flash_config_record_scanner.sv */
// flash config record scanner: slot checking, scan summary and result register
//
// Input channel: one flash byte per transaction, in slot order; slot_end marks the
// last byte of a slot and scan_end, taken with slot_end, the last slot of a scan.
// Every transaction with slot_end set produces one result transaction carrying the
// slot verdict and the running scan summary; other bytes produce none.
// Config channel: cfg_index selects magic, version, current payload length, normal
// mode code or default active mode (indexes 0 to 4); cfg_ready is always high and
// other indexes are ignored. Write only while no scan is in flight.
// Throughput is one byte per cycle while the input is not stalled: the byte-wide crc
// step, header compares and summary update sit between the slot state registers and
// the result register. The result is valid the cycle after the slot's last byte is
// accepted. When the receiver stalls, the held result blocks new bytes only if
// out_ready stays low; a byte is taken in the same cycle the held result leaves.
// Reset clears slot state, the scan summary and the result valid flag, and loads the
// register defaults. After a scan_end result the slot index and summary clear.
`default_nettype none
module flash_config_record_scanner #(
	parameter int MAX_SLOTS = fcrs_pkg::FCRS_MAX_SLOTS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            slot_end,
	input  wire logic                            scan_end,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fcrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                     cfg_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 slot_valid,
	output logic                                 slot_blank,
	output logic [2:0]                           record_class,
	output logic                                 slot_mode_normal,
	output logic [3:0]                           latest_fast_slot,
	output logic [3:0]                           latest_normal_slot,
	output logic                                 fast_found,
	output logic                                 normal_found,
	output logic                                 active_mode_normal,
	output logic [3:0]                           first_blank_slot,
	output logic                                 blank_found,
	output logic                                 needs_migration
);
	import fcrs_pkg::*;

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SLOTS - 1);

	cfg_t      cfg_q;
	logic      default_nrm_q;
	slot_res_t res;
	logic      accept, done;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] fast_slot_q, fast_slot_d;
	logic [IDX_W-1:0] norm_slot_q, norm_slot_d;
	logic [IDX_W-1:0] blank_slot_q, blank_slot_d;
	logic fast_found_q, fast_found_d;
	logic norm_found_q, norm_found_d;
	logic any_valid_q, any_valid_d;
	logic last_nrm_q, last_nrm_d;
	logic blank_found_q, blank_found_d;
	logic migrate_q, migrate_d;

	logic [IDX_W+3:0] fast_ext, norm_ext, blank_ext;

	logic        out_valid_q;
	slot_res_t   res_q;
	logic [3:0]  fast_slot_o_q, norm_slot_o_q, blank_slot_o_q;
	logic        fast_found_o_q, norm_found_o_q, active_o_q, blank_found_o_q, migrate_o_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign done      = accept && slot_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic       <= MAGIC_RESET;
			cfg_q.version     <= VERSION_RESET;
			cfg_q.cur_len     <= CUR_LEN_RESET;
			cfg_q.normal_code <= NORMAL_RESET;
			default_nrm_q     <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAGIC:       cfg_q.magic       <= cfg_data;
				REG_VERSION:     cfg_q.version     <= cfg_data[15:0];
				REG_CUR_LEN:     cfg_q.cur_len     <= cfg_data[9:0];
				REG_NORMAL_CODE: cfg_q.normal_code <= cfg_data[7:0];
				REG_DEFAULT_NRM: default_nrm_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	fcrs_slot_check u_slot_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (accept),
		.data_byte (data_byte),
		.slot_end  (slot_end),
		.cfg       (cfg_q),
		.res       (res)
	);

	// summary as it stands once this slot is counted
	always_comb begin
		fast_slot_d   = fast_slot_q;
		norm_slot_d   = norm_slot_q;
		fast_found_d  = fast_found_q;
		norm_found_d  = norm_found_q;
		any_valid_d   = any_valid_q;
		last_nrm_d    = last_nrm_q;
		blank_slot_d  = blank_slot_q;
		blank_found_d = blank_found_q;
		migrate_d     = migrate_q;
		if (res.valid) begin
			any_valid_d = 1'b1;
			last_nrm_d  = res.normal;
			if (res.normal) begin
				norm_slot_d  = idx_q;
				norm_found_d = 1'b1;
			end else begin
				fast_slot_d  = idx_q;
				fast_found_d = 1'b1;
			end
			if (res.cls != CLS_CUR) migrate_d = 1'b1;
		end
		if (res.blank && !blank_found_q) begin
			blank_slot_d  = idx_q;
			blank_found_d = 1'b1;
		end
	end

	assign fast_ext  = {4'd0, fast_slot_d};
	assign norm_ext  = {4'd0, norm_slot_d};
	assign blank_ext = {4'd0, blank_slot_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			fast_slot_q   <= '0;
			norm_slot_q   <= '0;
			blank_slot_q  <= '0;
			fast_found_q  <= 1'b0;
			norm_found_q  <= 1'b0;
			any_valid_q   <= 1'b0;
			last_nrm_q    <= 1'b0;
			blank_found_q <= 1'b0;
			migrate_q     <= 1'b0;
		end else if (done) begin
			if (scan_end) begin
				idx_q         <= '0;
				fast_slot_q   <= '0;
				norm_slot_q   <= '0;
				blank_slot_q  <= '0;
				fast_found_q  <= 1'b0;
				norm_found_q  <= 1'b0;
				any_valid_q   <= 1'b0;
				last_nrm_q    <= 1'b0;
				blank_found_q <= 1'b0;
				migrate_q     <= 1'b0;
			end else begin
				if (idx_q < IDX_LAST) idx_q <= idx_q + 1'b1;
				fast_slot_q   <= fast_slot_d;
				norm_slot_q   <= norm_slot_d;
				blank_slot_q  <= blank_slot_d;
				fast_found_q  <= fast_found_d;
				norm_found_q  <= norm_found_d;
				any_valid_q   <= any_valid_d;
				last_nrm_q    <= last_nrm_d;
				blank_found_q <= blank_found_d;
				migrate_q     <= migrate_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q           <= res;
			fast_slot_o_q   <= fast_ext[3:0];
			norm_slot_o_q   <= norm_ext[3:0];
			blank_slot_o_q  <= blank_ext[3:0];
			fast_found_o_q  <= fast_found_d;
			norm_found_o_q  <= norm_found_d;
			active_o_q      <= any_valid_d ? last_nrm_d : default_nrm_q;
			blank_found_o_q <= blank_found_d;
			migrate_o_q     <= migrate_d;
		end
	end

	assign out_valid          = out_valid_q;
	assign slot_valid         = res_q.valid;
	assign slot_blank         = res_q.blank;
	assign record_class       = res_q.cls;
	assign slot_mode_normal   = res_q.normal;
	assign latest_fast_slot   = fast_slot_o_q;
	assign latest_normal_slot = norm_slot_o_q;
	assign fast_found         = fast_found_o_q;
	assign normal_found       = norm_found_o_q;
	assign active_mode_normal = active_o_q;
	assign first_blank_slot   = blank_slot_o_q;
	assign blank_found        = blank_found_o_q;
	assign needs_migration    = migrate_o_q;

	a_result_follows_slot_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && slot_end) |=> out_valid)
		else $error("no result after slot end");

	a_class_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot_valid == (record_class != CLS_NONE)))
		else $error("record class disagrees with slot verdict");

	a_normal_in_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && slot_mode_normal) |-> (slot_valid && normal_found && active_mode_normal))
		else $error("normal slot missing from summary");

	a_fast_in_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && slot_valid && !slot_mode_normal) |-> (fast_found && !active_mode_normal))
		else $error("fast slot missing from summary");

endmodule
`default_nettype wire

/* design/fcrs_slot_check.sv */
// per-slot byte tracking: header capture, crc, blank check and slot verdict
`default_nettype none
module fcrs_slot_check (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_en,
	input  wire logic [7:0]        data_byte,
	input  wire logic              slot_end,
	input  wire fcrs_pkg::cfg_t    cfg,
	output fcrs_pkg::slot_res_t    res
);
	import fcrs_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [63:0]      hdr_q, hdr_d;
	logic [31:0]      crc_stored_q, crc_stored_d;
	logic [31:0]      crc_q, crc_d;
	logic             blank_q, blank_d;
	logic [7:0]       mode_q, mode_d;
	rec_class_t       cls;
	logic [POS_W-1:0] pay_end;
	logic             crc_en;
	logic             valid;

	// header is complete long before any payload byte, so the class comes from the register
	assign cls     = length_class(hdr_q[63:48], cfg.cur_len);
	assign pay_end = (cls != CLS_NONE) ? ({1'b0, hdr_q[57:48]} + HDR_BYTES) : HDR_BYTES;
	assign crc_en  = (pos_q >= HDR_BYTES) && (cls != CLS_NONE) && (pos_q < pay_end);

	always_comb begin
		hdr_d        = hdr_q;
		crc_stored_d = crc_stored_q;
		if (pos_q < 11'd8) begin
			hdr_d[{pos_q[2:0], 3'b000} +: 8] = data_byte;
		end else if (pos_q < HDR_BYTES) begin
			crc_stored_d[{pos_q[1:0], 3'b000} +: 8] = data_byte;
		end
		crc_d   = crc_en ? crc32_byte(crc_q, data_byte) : crc_q;
		mode_d  = (pos_q == MODE_POS) ? data_byte : mode_q;
		blank_d = blank_q && (data_byte == BLANK_BYTE);
		pos_d   = (pos_q == POS_MAX) ? pos_q : pos_q + 11'd1;
	end

	// payload is complete only when the new byte count covers header plus length
	assign valid = (cls != CLS_NONE)
		&& (pos_d >= pay_end)
		&& (hdr_q[31:0] == cfg.magic)
		&& (hdr_q[47:32] == cfg.version)
		&& (~crc_d == crc_stored_d);

	always_comb begin
		res.valid  = valid;
		res.blank  = blank_d;
		res.cls    = valid ? cls : CLS_NONE;
		res.normal = valid && (cls == CLS_CUR || cls == CLS_V8 || cls == CLS_V7)
			&& (mode_d == cfg.normal_code);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_q        <= '0;
			crc_stored_q <= '0;
			crc_q        <= CRC_INIT;
			blank_q      <= 1'b1;
			mode_q       <= '0;
		end else if (byte_en) begin
			if (slot_end) begin
				pos_q        <= '0;
				hdr_q        <= '0;
				crc_stored_q <= '0;
				crc_q        <= CRC_INIT;
				blank_q      <= 1'b1;
				mode_q       <= '0;
			end else begin
				pos_q        <= pos_d;
				hdr_q        <= hdr_d;
				crc_stored_q <= crc_stored_d;
				crc_q        <= crc_d;
				blank_q      <= blank_d;
				mode_q       <= mode_d;
			end
		end
	end

endmodule
`default_nettype wire

/* dv/flash_config_record_scanner_test.sv */
// testbench for the flash config record scanner: byte stream stimulus checked against a predictor
`default_nettype none
module flash_config_record_scanner_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fcrs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int ID_BYTES = 8;
	localparam int POS_LIMIT = 65535;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last_byte;
		logic       last_slot;
	} flash_byte_t;

	typedef struct packed {
		logic       valid;
		logic       blank;
		rec_class_t cls;
		logic       normal;
		logic [3:0] fast_slot;
		logic [3:0] normal_slot;
		logic       fast_seen;
		logic       normal_seen;
		logic       active_normal;
		logic [3:0] blank_slot;
		logic       blank_seen;
		logic       migrate;
	} slot_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic slot_end = 1'b0;
	logic scan_end = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic slot_valid, slot_blank, slot_mode_normal;
	logic [2:0] record_class;
	logic [3:0] latest_fast_slot, latest_normal_slot, first_blank_slot;
	logic fast_found, normal_found, active_mode_normal, blank_found, needs_migration;

	flash_config_record_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.slot_end(slot_end),
		.scan_end(scan_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_valid(slot_valid),
		.slot_blank(slot_blank),
		.record_class(record_class),
		.slot_mode_normal(slot_mode_normal),
		.latest_fast_slot(latest_fast_slot),
		.latest_normal_slot(latest_normal_slot),
		.fast_found(fast_found),
		.normal_found(normal_found),
		.active_mode_normal(active_mode_normal),
		.first_blank_slot(first_blank_slot),
		.blank_found(blank_found),
		.needs_migration(needs_migration)
	);

	// register copies
	logic [31:0] cfg_magic = MAGIC_RESET;
	logic [15:0] cfg_version = VERSION_RESET;
	logic [9:0] cfg_cur_len = CUR_LEN_RESET;
	logic [7:0] cfg_normal_code = NORMAL_RESET;
	logic cfg_default_normal = 1'b1;

	// per-slot state
	int pos_q;
	logic [63:0] hdr_q;
	logic [31:0] crc_stored_q, crc_run_q;
	logic ff_q;
	logic [7:0] mode_q;

	// scan summary
	int slot_idx, fast_idx, normal_idx, blank_idx;
	logic fast_seen, normal_seen, any_valid, last_normal, blank_seen, migrate_seen;

	flash_byte_t pending_bytes[$];
	slot_verdict_t expected_verdicts[$];
	flash_byte_t on_wire;
	slot_verdict_t want;

	int idle_pct = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	logic rx_hold_req = 1'b0;
	logic rx_hold = 1'b0;
	int mismatch_count = 0;
	int results_seen = 0;
	int queued_count = 0;
	int slots_checked = 0;
	int scans_done = 0;
	int valid_total = 0;
	int blank_total = 0;
	int cfg_writes = 0;

	function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] r;
		logic fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

	// current length wins over the legacy ones
	function automatic rec_class_t class_of(input logic [15:0] len);
		if (len == {6'd0, cfg_cur_len})
			return CLS_CUR;
		case (len)
			LEN_V8: return CLS_V8;
			LEN_V7: return CLS_V7;
			LEN_V6: return CLS_V6;
			LEN_V5: return CLS_V5;
			default: return CLS_NONE;
		endcase
	endfunction

	task automatic clear_slot_state();
		pos_q = 0;
		hdr_q = '0;
		crc_stored_q = '0;
		crc_run_q = CRC_INIT;
		ff_q = 1'b1;
		mode_q = '0;
	endtask

	task automatic clear_scan_summary();
		slot_idx = 0;
		fast_idx = 0;
		normal_idx = 0;
		blank_idx = 0;
		fast_seen = 1'b0;
		normal_seen = 1'b0;
		any_valid = 1'b0;
		last_normal = 1'b0;
		blank_seen = 1'b0;
		migrate_seen = 1'b0;
	endtask

	task automatic absorb_flash_byte(input flash_byte_t fb);
		rec_class_t cls;
		int hdr_len;
		logic good, nrm;
		slot_verdict_t v;
		if (fb.data != BLANK_BYTE)
			ff_q = 1'b0;
		hdr_len = int'(hdr_q[63:48]);
		cls = class_of(hdr_q[63:48]);
		if (pos_q < ID_BYTES)
			hdr_q[pos_q*8 +: 8] = fb.data;
		else if (pos_q < int'(HDR_BYTES))
			crc_stored_q[(pos_q-ID_BYTES)*8 +: 8] = fb.data;
		else if (cls != CLS_NONE && pos_q - int'(HDR_BYTES) < hdr_len)
			crc_run_q = crc32_step(crc_run_q, fb.data);
		if (pos_q == int'(MODE_POS))
			mode_q = fb.data;
		if (pos_q < POS_LIMIT)
			pos_q++;
		if (fb.last_byte) begin
			hdr_len = int'(hdr_q[63:48]);
			cls = class_of(hdr_q[63:48]);
			good = pos_q >= int'(HDR_BYTES) && hdr_q[31:0] == cfg_magic
				&& hdr_q[47:32] == cfg_version && cls != CLS_NONE
				&& pos_q - int'(HDR_BYTES) >= hdr_len && (~crc_run_q) == crc_stored_q;
			nrm = good && (cls == CLS_CUR || cls == CLS_V8 || cls == CLS_V7)
				&& mode_q == cfg_normal_code;
			if (good) begin
				any_valid = 1'b1;
				last_normal = nrm;
				if (nrm) begin
					normal_idx = slot_idx;
					normal_seen = 1'b1;
				end else begin
					fast_idx = slot_idx;
					fast_seen = 1'b1;
				end
				if (cls != CLS_CUR)
					migrate_seen = 1'b1;
				valid_total++;
			end
			if (ff_q && !blank_seen) begin
				blank_idx = slot_idx;
				blank_seen = 1'b1;
			end
			if (ff_q)
				blank_total++;
			v.valid = good;
			v.blank = ff_q;
			v.cls = good ? cls : CLS_NONE;
			v.normal = nrm;
			v.fast_slot = 4'(fast_idx);
			v.normal_slot = 4'(normal_idx);
			v.fast_seen = fast_seen;
			v.normal_seen = normal_seen;
			v.active_normal = any_valid ? last_normal : cfg_default_normal;
			v.blank_slot = 4'(blank_idx);
			v.blank_seen = blank_seen;
			v.migrate = migrate_seen;
			expected_verdicts.push_back(v);
			slots_checked++;
			clear_slot_state();
			if (fb.last_slot) begin
				clear_scan_summary();
				scans_done++;
			end else if (slot_idx < FCRS_MAX_SLOTS - 1) begin
				slot_idx++;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("result %0d: %s expected %0h, got %0h", results_seen, name,
					exp_v, got_v);
		end
	endtask

	// clock and byte driver
	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				absorb_flash_byte(on_wire);
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
						tx_gap = $urandom_range(0, 5);
						in_valid <= 1'b0;
					end else begin
						on_wire = pending_bytes.pop_front();
						in_valid <= 1'b1;
						data_byte <= on_wire.data;
						slot_end <= on_wire.last_byte;
						scan_end <= on_wire.last_slot;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result %0d arrived with no slot outstanding", results_seen);
				end else begin
					want = expected_verdicts.pop_front();
					check_field("slot_valid", 32'(want.valid), 32'(slot_valid));
					check_field("slot_blank", 32'(want.blank), 32'(slot_blank));
					check_field("record_class", 32'(want.cls), 32'(record_class));
					check_field("slot_mode_normal", 32'(want.normal), 32'(slot_mode_normal));
					check_field("latest_fast_slot", 32'(want.fast_slot),
						32'(latest_fast_slot));
					check_field("latest_normal_slot", 32'(want.normal_slot),
						32'(latest_normal_slot));
					check_field("fast_found", 32'(want.fast_seen), 32'(fast_found));
					check_field("normal_found", 32'(want.normal_seen), 32'(normal_found));
					check_field("active_mode_normal", 32'(want.active_normal),
						32'(active_mode_normal));
					check_field("first_blank_slot", 32'(want.blank_slot),
						32'(first_blank_slot));
					check_field("blank_found", 32'(want.blank_seen), 32'(blank_found));
					check_field("needs_migration", 32'(want.migrate), 32'(needs_migration));
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				rx_gap = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one long receiver hold-off so the result register backs up into the input
	initial begin
		wait (rx_hold_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_MAGIC:       cfg_magic = value;
			REG_VERSION:     cfg_version = value[15:0];
			REG_CUR_LEN:     cfg_cur_len = value[9:0];
			REG_NORMAL_CODE: cfg_normal_code = value[7:0];
			REG_DEFAULT_NRM: cfg_default_normal = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] magic, input logic [15:0] ver,
			input logic [9:0] cur_len, input logic [7:0] code, input logic dflt);
		write_register(REG_MAGIC, magic);
		write_register(REG_VERSION, {16'($urandom), ver});
		write_register(REG_CUR_LEN, {22'd0, cur_len});
		write_register(REG_NORMAL_CODE, {24'd0, code});
		write_register(REG_DEFAULT_NRM, {31'd0, dflt});
		@(negedge clk);
	endtask

	task automatic wait_until_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// stray scan_end on inner bytes must be ignored by the block
	task automatic queue_slot(input logic [7:0] bytes[$], input logic last_slot);
		flash_byte_t fb;
		for (int i = 0; i < bytes.size(); i++) begin
			fb.data = bytes[i];
			fb.last_byte = (i == bytes.size() - 1);
			fb.last_slot = fb.last_byte ? last_slot : ($urandom_range(0, 15) == 0);
			pending_bytes.push_back(fb);
		end
		queued_count += bytes.size();
	endtask

	task automatic queue_pattern(input int n, input logic blank, input logic last_slot);
		logic [7:0] bytes[$];
		for (int i = 0; i < n; i++)
			bytes.push_back(blank ? BLANK_BYTE : 8'($urandom));
		queue_slot(bytes, last_slot);
	endtask

	task automatic queue_record(input logic [31:0] magic, input logic [15:0] ver,
			input logic [15:0] len, input int body_len, input logic [7:0] mode,
			input logic bad_crc, input logic last_slot);
		logic [7:0] bytes[$];
		logic [7:0] body[$];
		logic [63:0] id;
		logic [31:0] crc;
		crc = CRC_INIT;
		for (int i = 0; i < body_len; i++)
			body.push_back(i == int'(MODE_POS) - int'(HDR_BYTES) ? mode : 8'($urandom));
		for (int i = 0; i < body_len && i < int'(len); i++)
			crc = crc32_step(crc, body[i]);
		crc = ~crc;
		if (bad_crc)
			crc ^= 32'd1 << $urandom_range(0, 31);
		id = {len, ver, magic};
		for (int i = 0; i < ID_BYTES; i++)
			bytes.push_back(id[i*8 +: 8]);
		for (int i = 0; i < 4; i++)
			bytes.push_back(crc[i*8 +: 8]);
		for (int i = 0; i < body_len; i++)
			bytes.push_back(body[i]);
		queue_slot(bytes, last_slot);
	endtask

	function automatic logic [15:0] pick_length(input int pick);
		case (pick)
			0: return {6'd0, cfg_cur_len};
			1: return LEN_V8;
			2: return LEN_V7;
			3: return LEN_V6;
			default: return LEN_V5;
		endcase
	endfunction

	task automatic queue_random_slot(input logic last_slot);
		int kind, pick, body;
		logic [15:0] len, ver;
		logic [31:0] magic;
		logic [7:0] mode;
		logic bad_crc;
		kind = $urandom_range(0, 99);
		magic = cfg_magic;
		ver = cfg_version;
		bad_crc = 1'b0;
		mode = $urandom_range(0, 1) ? cfg_normal_code : 8'($urandom);
		if (kind < 22) begin
			// well-formed record with random content, now and then broken
			pick = $urandom_range(0, 4);
			if (pick == 0 && cfg_cur_len > 300 && $urandom_range(0, 3) != 0)
				pick = $urandom_range(1, 4);
			len = pick_length(pick);
			body = int'(len) + $urandom_range(0, 16);
			case ($urandom_range(0, 19))
				0, 1: bad_crc = 1'b1;
				2: body = $urandom_range(0, int'(len) - 1);
				3: magic ^= 32'd1 << $urandom_range(0, 31);
				4: ver ^= 16'd1 << $urandom_range(0, 15);
				default: ;
			endcase
			queue_record(magic, ver, len, body, mode, bad_crc, last_slot);
		end else if (kind < 37) begin
			queue_pattern($urandom_range(1, 20), 1'b1, last_slot);
		end else if (kind < 52) begin
			len = $urandom_range(0, 1) ? 16'($urandom) : pick_length($urandom_range(0, 4));
			queue_record(magic, ver, len, $urandom_range(0, 20), mode, 1'b0, last_slot);
		end else begin
			queue_pattern($urandom_range(1, 24), 1'b0, last_slot);
		end
	endtask

	task automatic run_random_phase(input int min_bytes, input int min_slots);
		int start_bytes, n;
		start_bytes = queued_count;
		n = 0;
		while (queued_count - start_bytes < min_bytes || n < min_slots) begin
			queue_random_slot($urandom_range(0, 4) == 0);
			n++;
		end
		queue_random_slot(1'b1);
	endtask

	initial begin
		clear_slot_state();
		clear_scan_summary();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed scan at reset settings: a current record and the cheap ways a slot fails
		idle_pct = 8;
		queue_pattern(1, 1'b1, 1'b0);
		queue_record(cfg_magic, cfg_version, {6'd0, cfg_cur_len}, 256, cfg_normal_code,
			1'b0, 1'b0);
		queue_record(cfg_magic ^ 32'h8000_0000, cfg_version, LEN_V8, 8, 8'h00, 1'b0, 1'b0);
		queue_record(cfg_magic, cfg_version ^ 16'h8000, LEN_V8, 8, 8'h00, 1'b0, 1'b0);
		queue_record(cfg_magic, cfg_version, 16'd250, 8, 8'h00, 1'b0, 1'b0);
		queue_record(cfg_magic, cfg_version, {6'd0, cfg_cur_len}, 20, cfg_normal_code,
			1'b0, 1'b0);
		queue_pattern(5, 1'b0, 1'b0);
		queue_pattern(8, 1'b1, 1'b1);
		// more slots than the index can count
		for (int i = 0; i < 17; i++)
			queue_pattern($urandom_range(1, 3), 1'b0, 1'b0);
		// v6 record, fast; its body ends just before the mode byte position
		queue_record(cfg_magic, cfg_version, LEN_V6, 243, cfg_normal_code, 1'b0, 1'b1);
		wait_until_drained();

		// low extremes, with the long receiver hold-off
		configure(32'h0000_0000, 16'h0000, 10'd254, 8'h00, 1'b0);
		write_register(REG_UNUSED, 32'($urandom));
		@(negedge clk);
		idle_pct = 15;
		run_random_phase(0, 2);
		rx_hold_req = 1'b1;
		wait_until_drained();

		// high extremes
		configure(32'hFFFF_FFFF, 16'hFFFF, 10'd1012, 8'hFF, 1'b1);
		idle_pct = 5;
		run_random_phase(0, 2);
		wait_until_drained();

		configure(32'($urandom), 16'($urandom), 10'($urandom_range(254, 300)),
			8'($urandom), 1'($urandom));
		idle_pct = 10;
		run_random_phase(0, 2);
		wait_until_drained();

		// closing stretch runs flat out
		configure(32'($urandom), 16'($urandom), 10'($urandom_range(254, 300)),
			8'($urandom), 1'($urandom));
		idle_pct = 0;
		run_random_phase(0, 2);
		wait_until_drained();

		$display("checked %0d slots in %0d scans (%0d valid records, %0d blank slots)",
			slots_checked, scans_done, valid_total, blank_total);
		$display("from %0d bytes under %0d register writes", queued_count, cfg_writes);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
design/fcrs_pkg.sv
design/fcrs_slot_check.sv
design/flash_config_record_scanner.sv
dv/flash_config_record_scanner_test.sv
